[rtl/lowest_common_ancestor_lifting_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the lowest common ancestor block
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LOWEST_COMMON_ANCESTOR_LIFTING_DEFINES_SVH
`define LOWEST_COMMON_ANCESTOR_LIFTING_DEFINES_SVH

// Checked only while the block is out of reset.
`define LCAL_ASSERT_ON(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define LCAL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/lcal_pkg.sv]
// ----------------------------------------------------------------------------
// lcal_pkg
// Shared types, codes and helpers of the binary-lifting ancestor engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcal_pkg;

    localparam int FIELD_W    = 10;
    localparam int KIND_W     = 2;
    localparam int LVL_W      = 5;
    localparam int NODES_DEF  = 1024;
    localparam int LEVELS_DEF = 10;

    typedef logic [FIELD_W-1:0] t_node;
    typedef logic [KIND_W-1:0]  t_kind;
    typedef logic [LVL_W-1:0]   t_lvl;

    localparam t_kind K_LOAD  = 2'd0;
    localparam t_kind K_BUILD = 2'd1;
    localparam t_kind K_QUERY = 2'd2;

    typedef struct packed {
        logic  wr_en;
        t_node wr_row;
        t_lvl  wr_lvl;
        t_node wr_data;
        logic  dwr_en;
        t_node dwr_data;
        t_node rd_a_row;
        t_lvl  rd_a_lvl;
        t_node rd_b_row;
        t_lvl  rd_b_lvl;
    } t_tbl_req;

    typedef struct packed {
        t_node jump_a;
        t_node jump_b;
        t_node depth_a;
        t_node depth_b;
    } t_tbl_rsp;

    // Node 0 and any node at or above the node count act as the sentinel.
    function automatic logic f_snt(input t_node n, input int nodes);
        return (n == '0) || (int'(n) >= nodes);
    endfunction

endpackage

`default_nettype wire

[rtl/lcal_if.sv]
// ----------------------------------------------------------------------------
// lcal_if
// Valid/ready channels carrying request words and ancestor words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lcal_in_if
    import lcal_pkg::*;
;
    logic  valid;
    logic  ready;
    t_kind kind;
    t_node node_a;
    t_node node_b;
    t_node node_depth;

    modport source (output valid, output kind, output node_a, output node_b,
                    output node_depth, input ready);
    modport sink   (input valid, input kind, input node_a, input node_b,
                    input node_depth, output ready);
endinterface

interface lcal_out_if
    import lcal_pkg::*;
;
    logic  valid;
    logic  ready;
    t_node ancestor;

    modport source (output valid, output ancestor, input ready);
    modport sink   (input valid, input ancestor, output ready);
endinterface

`default_nettype wire

[rtl/lcal_tables.sv]
// ----------------------------------------------------------------------------
// lcal_tables
// Jump table and depth table, one write to each and two registered reads of each per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcal_tables
    import lcal_pkg::*;
#(
    parameter int NODES  = NODES_DEF,
    parameter int LEVELS = LEVELS_DEF
) (
    input  wire logic     i_clk,
    input  wire t_tbl_req i_req,
    output t_tbl_rsp      o_rsp
);

    localparam int ROWS = (NODES > (1 << FIELD_W)) ? (1 << FIELD_W) : NODES;
    localparam int NIW  = $clog2(ROWS);
    localparam int LVW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    t_node r_jump_mem [ROWS][LEVELS];
    t_node r_depth_mem [ROWS];
    t_node r_ja;
    t_node r_jb;
    t_node r_da;
    t_node r_db;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_jump_mem[i_req.wr_row[NIW-1:0]][i_req.wr_lvl[LVW-1:0]] <= i_req.wr_data;
        end
        if (i_req.dwr_en) begin
            r_depth_mem[i_req.wr_row[NIW-1:0]] <= i_req.dwr_data;
        end
        r_ja <= r_jump_mem[i_req.rd_a_row[NIW-1:0]][i_req.rd_a_lvl[LVW-1:0]];
        r_jb <= r_jump_mem[i_req.rd_b_row[NIW-1:0]][i_req.rd_b_lvl[LVW-1:0]];
        r_da <= r_depth_mem[i_req.rd_a_row[NIW-1:0]];
        r_db <= r_depth_mem[i_req.rd_b_row[NIW-1:0]];
    end

    assign o_rsp.jump_a  = r_ja;
    assign o_rsp.jump_b  = r_jb;
    assign o_rsp.depth_a = r_da;
    assign o_rsp.depth_b = r_db;

endmodule

`default_nettype wire

[rtl/lcal_seq.sv]
// ----------------------------------------------------------------------------
// lcal_seq
// Sequencer for loads, level builds and ancestor queries over the tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcal_seq
    import lcal_pkg::*;
#(
    parameter int NODES  = NODES_DEF,
    parameter int LEVELS = LEVELS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_kind    i_kind,
    input  wire t_node    i_node_a,
    input  wire t_node    i_node_b,
    input  wire t_node    i_node_depth,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_node         o_ancestor,
    output t_tbl_req      o_tbl_req,
    input  wire t_tbl_rsp i_tbl_rsp
);

    localparam int ROWS = (NODES > (1 << FIELD_W)) ? (1 << FIELD_W) : NODES;
    localparam int NIW  = $clog2(ROWS);
    localparam int LVW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_BRD  = 4'd1;
    localparam logic [3:0] S_BFET = 4'd2;
    localparam logic [3:0] S_BWR  = 4'd3;
    localparam logic [3:0] S_QDEP = 4'd4;
    localparam logic [3:0] S_QLFT = 4'd5;
    localparam logic [3:0] S_QLW  = 4'd6;
    localparam logic [3:0] S_QEQ  = 4'd7;
    localparam logic [3:0] S_QCMP = 4'd8;
    localparam logic [3:0] S_QFIN = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0]     r_state, n_state;
    t_node          r_a, n_a;
    t_node          r_b, n_b;
    logic           r_sa, n_sa;
    logic           r_sb, n_sb;
    t_node          r_diff, n_diff;
    logic [LVW-1:0] r_lv, n_lv;
    logic [NIW-1:0] r_i, n_i;
    logic [LVW-1:0] r_j, n_j;
    t_node          r_res, n_res;
    logic           r_ov, n_ov;
    t_node          r_anc, n_anc;

    logic        w_acc;
    t_node       w_ja;
    t_node       w_jb;
    t_node       w_da;
    t_node       w_db;
    t_node       w_na;
    t_node       w_nb;
    logic [31:0] w_diff_sh;
    logic        w_bit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_acc       = i_in_valid && o_in_ready;
    assign o_out_valid = r_ov;
    assign o_ancestor  = r_anc;

    assign w_ja      = r_sa ? '0 : i_tbl_rsp.jump_a;
    assign w_jb      = r_sb ? '0 : i_tbl_rsp.jump_b;
    assign w_da      = r_sa ? '0 : i_tbl_rsp.depth_a;
    assign w_db      = r_sb ? '0 : i_tbl_rsp.depth_b;
    assign w_na      = (w_ja != w_jb) ? w_ja : r_a;
    assign w_nb      = (w_ja != w_jb) ? w_jb : r_b;
    assign w_diff_sh = 32'(r_diff) >> r_lv;
    assign w_bit     = w_diff_sh[0];

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_sa    = r_sa;
        n_sb    = r_sb;
        n_diff  = r_diff;
        n_lv    = r_lv;
        n_i     = r_i;
        n_j     = r_j;
        n_res   = r_res;
        n_ov    = r_ov;
        n_anc   = r_anc;

        o_tbl_req          = '0;
        o_tbl_req.wr_row   = i_node_a;
        o_tbl_req.wr_data  = i_node_b;
        o_tbl_req.dwr_data = i_node_depth;
        o_tbl_req.rd_a_row = i_node_a;
        o_tbl_req.rd_b_row = i_node_b;

        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (i_kind)
                        K_LOAD: begin
                            if (!f_snt(i_node_a, NODES)) begin
                                o_tbl_req.wr_en  = 1'b1;
                                o_tbl_req.dwr_en = 1'b1;
                            end
                        end
                        K_BUILD: begin
                            if (LEVELS > 1) begin
                                n_i     = NIW'(1);
                                n_j     = LVW'(1);
                                n_state = S_BRD;
                            end
                        end
                        K_QUERY: begin
                            n_a     = i_node_a;
                            n_b     = i_node_b;
                            n_sa    = f_snt(i_node_a, NODES);
                            n_sb    = f_snt(i_node_b, NODES);
                            n_state = S_QDEP;
                        end
                        default: ;
                    endcase
                end
            end
            S_BRD: begin
                o_tbl_req.rd_a_row = t_node'(r_i);
                o_tbl_req.rd_a_lvl = t_lvl'(r_j - LVW'(1));
                n_state            = S_BFET;
            end
            S_BFET: begin
                o_tbl_req.rd_a_row = i_tbl_rsp.jump_a;
                o_tbl_req.rd_a_lvl = t_lvl'(r_j - LVW'(1));
                n_sa               = f_snt(i_tbl_rsp.jump_a, NODES);
                n_state            = S_BWR;
            end
            S_BWR: begin
                o_tbl_req.wr_en   = 1'b1;
                o_tbl_req.wr_row  = t_node'(r_i);
                o_tbl_req.wr_lvl  = t_lvl'(r_j);
                o_tbl_req.wr_data = w_ja;
                if (r_i == NIW'(ROWS - 1)) begin
                    if (r_j == LVW'(LEVELS - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_j                = r_j + LVW'(1);
                        n_i                = NIW'(1);
                        o_tbl_req.rd_a_row = t_node'(NIW'(1));
                        o_tbl_req.rd_a_lvl = t_lvl'(r_j);
                        n_state            = S_BFET;
                    end
                end else begin
                    n_i                = r_i + NIW'(1);
                    o_tbl_req.rd_a_row = t_node'(NIW'(r_i + NIW'(1)));
                    o_tbl_req.rd_a_lvl = t_lvl'(r_j - LVW'(1));
                    n_state            = S_BFET;
                end
            end
            S_QDEP: begin
                if (w_da > w_db) begin
                    n_a    = r_b;
                    n_b    = r_a;
                    n_sa   = r_sb;
                    n_sb   = r_sa;
                    n_diff = w_da - w_db;
                end else begin
                    n_diff = w_db - w_da;
                end
                n_lv    = LVW'(LEVELS - 1);
                n_state = S_QLFT;
            end
            S_QLFT: begin
                if (w_bit) begin
                    o_tbl_req.rd_b_row = r_b;
                    o_tbl_req.rd_b_lvl = t_lvl'(r_lv);
                    n_state            = S_QLW;
                end else if (r_lv == '0) begin
                    n_state = S_QEQ;
                end else begin
                    n_lv = r_lv - LVW'(1);
                end
            end
            S_QLW: begin
                n_b  = w_jb;
                n_sb = f_snt(w_jb, NODES);
                if (r_lv == '0) begin
                    n_state = S_QEQ;
                end else begin
                    n_lv    = r_lv - LVW'(1);
                    n_state = S_QLFT;
                end
            end
            S_QEQ: begin
                if (r_a == r_b) begin
                    n_res   = r_a;
                    n_state = S_DONE;
                end else begin
                    o_tbl_req.rd_a_row = r_a;
                    o_tbl_req.rd_b_row = r_b;
                    o_tbl_req.rd_a_lvl = t_lvl'(LVW'(LEVELS - 1));
                    o_tbl_req.rd_b_lvl = t_lvl'(LVW'(LEVELS - 1));
                    n_lv               = LVW'(LEVELS - 1);
                    n_state            = S_QCMP;
                end
            end
            S_QCMP: begin
                n_a                = w_na;
                n_b                = w_nb;
                n_sa               = f_snt(w_na, NODES);
                n_sb               = f_snt(w_nb, NODES);
                o_tbl_req.rd_a_row = w_na;
                o_tbl_req.rd_b_row = w_nb;
                if (r_lv == '0) begin
                    n_state = S_QFIN;
                end else begin
                    o_tbl_req.rd_a_lvl = t_lvl'(r_lv - LVW'(1));
                    o_tbl_req.rd_b_lvl = t_lvl'(r_lv - LVW'(1));
                    n_lv               = r_lv - LVW'(1);
                end
            end
            S_QFIN: begin
                n_res   = w_ja;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || i_out_ready) begin
                    n_ov    = 1'b1;
                    n_anc   = r_res;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_sa   <= n_sa;
        r_sb   <= n_sb;
        r_diff <= n_diff;
        r_lv   <= n_lv;
        r_i    <= n_i;
        r_j    <= n_j;
        r_res  <= n_res;
        r_anc  <= n_anc;
    end

endmodule

`default_nettype wire

[rtl/lowest_common_ancestor_lifting.sv]
// ----------------------------------------------------------------------------
// lowest_common_ancestor_lifting
// Binary-lifting engine that loads a rooted tree and answers common ancestor
// queries.
// ----------------------------------------------------------------------------
// Usage: words enter on i_in; kind selects load (parent and depth of node_a),
// build (fills jump levels 1 and up) or query (node_a, node_b). A query gives
// one word on o_out with the lowest common ancestor; other kinds give none.
// A load writes both tables unless node_a is a sentinel; the block stays ready.
// A build fills jump levels 1 and up for rows 1 to ROWS - 1, with ROWS the
// smaller of NODES and 1024; each entry needs two dependent table reads.
// From acceptance to the result, a query does a depth read, lifts the
// deeper node level by level, then lifts both nodes level by level, all
// through the single jump table read pair.
// The block takes one word at a time and is not ready while it works.
// Reset empties the output register and returns the sequencer to idle; the
// tables are not cleared, since node 0 is answered as the sentinel in logic.
// If the receiver stalls, the result waits in the output register; a new
// word is still taken, and a later query holds until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lowest_common_ancestor_lifting
    import lcal_pkg::*;
#(
    parameter int NODES  = NODES_DEF,
    parameter int LEVELS = LEVELS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lcal_in_if.sink    i_in,
    lcal_out_if.source o_out
);

    t_tbl_req w_req;
    t_tbl_rsp w_rsp;

    lcal_seq #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .o_in_ready   (i_in.ready),
        .i_kind       (i_in.kind),
        .i_node_a     (i_in.node_a),
        .i_node_b     (i_in.node_b),
        .i_node_depth (i_in.node_depth),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_ancestor   (o_out.ancestor),
        .o_tbl_req    (w_req),
        .i_tbl_rsp    (w_rsp)
    );

    lcal_tables #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_tables (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

endmodule

`default_nettype wire

[rtl/lcal_checker.sv]
// ----------------------------------------------------------------------------
// lcal_checker
// Port-level checks of the ancestor engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lowest_common_ancestor_lifting_defines.svh"

module lcal_checker
    import lcal_pkg::*;
(
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    input wire logic  i_in_valid,
    input wire logic  i_in_ready,
    input wire t_kind i_in_kind,
    input wire logic  i_out_valid,
    input wire logic  i_out_ready,
    input wire t_node i_out_ancestor
);

    `LCAL_ASSERT_ON(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "Result word dropped while stalled")
    `LCAL_ASSERT_ON(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_ancestor), "Result word changed while stalled")
    `LCAL_ASSERT_ON(a_query_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_kind == K_QUERY) |=> !i_in_ready, "Ready after a query was accepted")
    `LCAL_ASSERT_ON(a_load_fast, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_kind == K_LOAD) |=> i_in_ready, "Not ready after a load")
    `LCAL_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid && i_in_ready, "Block not idle after reset")

endmodule

bind lowest_common_ancestor_lifting lcal_checker u_lcal_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_kind      (i_in.kind),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_ancestor (o_out.ancestor)
);

`default_nettype wire
